// ----- hdl/prqt_pkg.sv -----
// ----------------------------------------------------------------------------
// prqt_pkg
// Shared types and constants for the priority request queue with tags.
// ----------------------------------------------------------------------------
package prqt_pkg;

  localparam int NUM_IDS     = 64;
  localparam int ID_BASE     = 1;
  localparam int PAYLOAD_W   = 32;
  localparam int NUM_CLASSES = 3;

  localparam int PTR_W   = $clog2(NUM_IDS);
  localparam int CNT_W   = $clog2(NUM_IDS + 1);
  localparam int TAG_W   = 7;
  localparam int PL_W    = 32;
  localparam int CLS_W   = 2;
  localparam int ADDR_W  = $clog2(NUM_CLASSES * NUM_IDS);
  localparam int ENTRY_W = TAG_W + PAYLOAD_W;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_REL = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_TAG = 2'd1,
    STS_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_HIGH   = 2'd1,
    CLS_MAX    = 2'd2
  } class_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

endpackage

// ----- hdl/priority_request_queue_with_tags.sv -----
// ----------------------------------------------------------------------------
// priority_request_queue_with_tags
// Strict-priority request queue (max, high, normal) with a lowest-free tag
// allocator. Queue entries sit in one synchronous memory; tag pool, heads,
// tails and counts are registers.
// Latency: result strobed on the cycle after the start transfer.
// A new start is not taken until the result of the last one has been shown.
// busy is high during the result cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous): all tags free, all queues empty, idle.
// ----------------------------------------------------------------------------
module priority_request_queue_with_tags (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [1:0]                    in_priority_req,
  input  logic [prqt_pkg::PL_W-1:0]     in_payload,
  input  logic [prqt_pkg::TAG_W-1:0]    in_release_tag,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [prqt_pkg::TAG_W-1:0]    out_tag,
  output logic [prqt_pkg::PL_W-1:0]     out_payload_out
);

  localparam int NC = prqt_pkg::NUM_CLASSES;

  prqt_pkg::state_t state_r, state_nxt;

  logic [prqt_pkg::NUM_IDS-1:0] in_use_r, in_use_nxt;
  logic [prqt_pkg::PTR_W-1:0]   head_r [NC];
  logic [prqt_pkg::PTR_W-1:0]   tail_r [NC];
  logic [prqt_pkg::CNT_W-1:0]   cnt_r  [NC];
  logic [prqt_pkg::PTR_W-1:0]   head_nxt [NC];
  logic [prqt_pkg::PTR_W-1:0]   tail_nxt [NC];
  logic [prqt_pkg::CNT_W-1:0]   cnt_nxt  [NC];

  logic [prqt_pkg::ENTRY_W-1:0] mem [prqt_pkg::NUM_CLASSES * prqt_pkg::NUM_IDS];
  logic [prqt_pkg::ENTRY_W-1:0] mem_rdata_r;
  logic                         mem_we, mem_re;
  logic [prqt_pkg::ADDR_W-1:0]  mem_addr;
  logic [prqt_pkg::ENTRY_W-1:0] mem_wdata;

  logic [1:0]                   res_status_r, res_status_nxt;
  logic [prqt_pkg::TAG_W-1:0]   res_tag_r, res_tag_nxt;
  logic                         res_deq_r, res_deq_nxt;

  logic                         accept;
  prqt_pkg::opcode_t            op;
  logic [prqt_pkg::CLS_W-1:0]   enq_cls, deq_cls, sel_cls;
  logic                         deq_any;
  logic [prqt_pkg::PTR_W-1:0]   free_idx;
  logic                         free_any;
  logic [prqt_pkg::CNT_W-1:0]   sel_cnt;
  logic [prqt_pkg::PTR_W-1:0]   sel_ptr;
  logic [prqt_pkg::PTR_W-1:0]   sel_ptr_inc;
  logic                         enq_ok, deq_ok;
  logic                         rel_hit;
  logic [prqt_pkg::TAG_W-1:0]   rel_off;

  assign accept = start && (state_r == prqt_pkg::S_IDLE);
  assign op     = prqt_pkg::opcode_t'(in_opcode);

  assign enq_cls = (in_priority_req == prqt_pkg::CLS_NORMAL) ? prqt_pkg::CLS_NORMAL :
                   (in_priority_req == prqt_pkg::CLS_HIGH)   ? prqt_pkg::CLS_HIGH :
                                                               prqt_pkg::CLS_MAX;

  always_comb begin
    deq_any = 1'b1;
    deq_cls = prqt_pkg::CLS_MAX;
    if (cnt_r[prqt_pkg::CLS_MAX] != '0) begin
      deq_cls = prqt_pkg::CLS_MAX;
    end else if (cnt_r[prqt_pkg::CLS_HIGH] != '0) begin
      deq_cls = prqt_pkg::CLS_HIGH;
    end else if (cnt_r[prqt_pkg::CLS_NORMAL] != '0) begin
      deq_cls = prqt_pkg::CLS_NORMAL;
    end else begin
      deq_any = 1'b0;
    end
  end

  // lowest free tag
  always_comb begin
    free_idx = '0;
    for (int i = prqt_pkg::NUM_IDS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_idx = prqt_pkg::PTR_W'(i);
      end
    end
  end
  assign free_any = ~&in_use_r;

  assign sel_cls     = (op == prqt_pkg::OP_DEQ) ? deq_cls : enq_cls;
  assign sel_cnt     = cnt_r[sel_cls];
  assign sel_ptr     = (op == prqt_pkg::OP_DEQ) ? head_r[sel_cls] : tail_r[sel_cls];
  assign sel_ptr_inc = (sel_ptr == prqt_pkg::PTR_W'(prqt_pkg::NUM_IDS - 1)) ? '0 :
                       sel_ptr + 1'b1;

  assign enq_ok = accept && (op == prqt_pkg::OP_ENQ) && free_any &&
                  (sel_cnt < prqt_pkg::CNT_W'(prqt_pkg::NUM_IDS));
  assign deq_ok = accept && (op == prqt_pkg::OP_DEQ) && deq_any;

  assign rel_off = in_release_tag - prqt_pkg::TAG_W'(prqt_pkg::ID_BASE);
  assign rel_hit = accept && (op == prqt_pkg::OP_REL) &&
                   (in_release_tag >= prqt_pkg::TAG_W'(prqt_pkg::ID_BASE)) &&
                   (rel_off < prqt_pkg::TAG_W'(prqt_pkg::NUM_IDS));

  assign mem_we    = enq_ok;
  assign mem_re    = deq_ok;
  assign mem_addr  = prqt_pkg::ADDR_W'(sel_cls) * prqt_pkg::ADDR_W'(prqt_pkg::NUM_IDS) +
                     prqt_pkg::ADDR_W'(sel_ptr);
  assign mem_wdata = {prqt_pkg::TAG_W'(free_idx) + prqt_pkg::TAG_W'(prqt_pkg::ID_BASE),
                      in_payload[prqt_pkg::PAYLOAD_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  // queue and pool update
  always_comb begin
    in_use_nxt = in_use_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    if (enq_ok) begin
      in_use_nxt[free_idx] = 1'b1;
      tail_nxt[sel_cls]    = sel_ptr_inc;
      cnt_nxt[sel_cls]     = sel_cnt + 1'b1;
    end
    if (deq_ok) begin
      head_nxt[sel_cls] = sel_ptr_inc;
      cnt_nxt[sel_cls]  = sel_cnt - 1'b1;
    end
    if (rel_hit) begin
      in_use_nxt[rel_off[prqt_pkg::PTR_W-1:0]] = 1'b0;
    end
  end

  // result capture
  always_comb begin
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_deq_nxt    = res_deq_r;
    if (accept) begin
      res_status_nxt = prqt_pkg::STS_OK;
      res_tag_nxt    = '0;
      res_deq_nxt    = deq_ok;
      case (op)
        prqt_pkg::OP_ENQ: begin
          if (enq_ok) begin
            res_tag_nxt = mem_wdata[prqt_pkg::ENTRY_W-1 -: prqt_pkg::TAG_W];
          end else begin
            res_status_nxt = prqt_pkg::STS_NO_TAG;
          end
        end
        prqt_pkg::OP_DEQ: begin
          if (!deq_any) begin
            res_status_nxt = prqt_pkg::STS_EMPTY;
          end
        end
        default: begin
          res_status_nxt = prqt_pkg::STS_OK;
        end
      endcase
    end
  end

  always_comb begin
    case (state_r)
      prqt_pkg::S_IDLE: state_nxt = start ? prqt_pkg::S_RESP : prqt_pkg::S_IDLE;
      prqt_pkg::S_RESP: state_nxt = prqt_pkg::S_IDLE;
      default:          state_nxt = prqt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b0;
    out_valid       = 1'b0;
    out_status      = prqt_pkg::STS_OK;
    out_tag         = '0;
    out_payload_out = '0;
    case (state_r)
      prqt_pkg::S_RESP: begin
        busy       = 1'b1;
        out_valid  = 1'b1;
        out_status = res_status_r;
        if (res_deq_r) begin
          out_tag         = mem_rdata_r[prqt_pkg::ENTRY_W-1 -: prqt_pkg::TAG_W];
          out_payload_out = prqt_pkg::PL_W'(mem_rdata_r[prqt_pkg::PAYLOAD_W-1:0]);
        end else begin
          out_tag = res_tag_r;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= prqt_pkg::S_IDLE;
      in_use_r  <= '0;
      res_deq_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      in_use_r  <= in_use_nxt;
      res_deq_r <= res_deq_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
  end

endmodule

// ----- hdl/prqt_checker.sv -----
// ----------------------------------------------------------------------------
// prqt_checker
// Port-level checks on the priority request queue, bound to the top level.
// ----------------------------------------------------------------------------
module prqt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_opcode,
  input logic                       out_valid,
  input logic [1:0]                 out_status,
  input logic [prqt_pkg::TAG_W-1:0] out_tag,
  input logic [prqt_pkg::PL_W-1:0]  out_payload_out
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after start transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != prqt_pkg::STS_OK) |-> (out_tag == '0 && out_payload_out == '0))
    else $error("failed operation returned tag or payload");

  a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == prqt_pkg::OP_REL) |=>
      (out_status == prqt_pkg::STS_OK && out_tag == '0 && out_payload_out == '0))
    else $error("release result not clean");

  a_enq_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == prqt_pkg::OP_ENQ) |=>
      (out_status == prqt_pkg::STS_NO_TAG || out_tag != '0))
    else $error("enqueue succeeded without a tag");

endmodule

bind priority_request_queue_with_tags prqt_checker u_prqt_checker (.*);

// ----- verif/priority_request_queue_with_tags_tb.sv -----
// ----------------------------------------------------------------------------
// priority_request_queue_with_tags_tb
// Self-checking bench for the strict-priority request queue with tags. A short
// table of directed operations runs first. Then the bench fills the tag pool,
// overfills one class queue and drains it. Random enqueue, dequeue and release
// traffic in bursts follows. Each reply is checked against a local model of
// the tag pool and the three class queues.
// ----------------------------------------------------------------------------
module priority_request_queue_with_tags_tb;

  typedef struct {
    prqt_pkg::opcode_t                 op;
    logic [prqt_pkg::CLS_W-1:0]        prio;
    logic [prqt_pkg::PL_W-1:0]         payload;
    logic [prqt_pkg::TAG_W-1:0]        rtag;
  } queue_req_t;

  typedef struct {
    prqt_pkg::status_t                 status;
    logic [prqt_pkg::TAG_W-1:0]        tag;
    logic [prqt_pkg::PL_W-1:0]         payload;
  } queue_reply_t;

  typedef struct {
    queue_req_t   req;
    bit           fixed;
    queue_reply_t want;
  } script_row_t;

  typedef struct packed {
    logic [prqt_pkg::TAG_W-1:0] tag;
    logic [prqt_pkg::PL_W-1:0]  data;
  } queue_slot_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  in_opcode = prqt_pkg::OP_NOP;
  logic [1:0]                  in_priority_req = '0;
  logic [prqt_pkg::PL_W-1:0]   in_payload = '0;
  logic [prqt_pkg::TAG_W-1:0]  in_release_tag = '0;
  logic                        out_valid;
  logic [1:0]                  out_status;
  logic [prqt_pkg::TAG_W-1:0]  out_tag;
  logic [prqt_pkg::PL_W-1:0]   out_payload_out;

  // model of the block
  bit                  tag_live [prqt_pkg::NUM_IDS];
  queue_slot_t         class_slots [prqt_pkg::NUM_CLASSES][prqt_pkg::NUM_IDS];
  int unsigned         class_head [prqt_pkg::NUM_CLASSES];
  int unsigned         class_tail [prqt_pkg::NUM_CLASSES];
  int unsigned         class_fill [prqt_pkg::NUM_CLASSES];

  queue_reply_t        pending_replies [$];
  script_row_t         script [$];
  int unsigned         mismatches = 0;
  int unsigned         n_items = 0;
  int unsigned         n_alloc = 0;
  int unsigned         n_refused = 0;
  int unsigned         n_served = 0;
  int unsigned         n_empty = 0;
  int unsigned         n_release = 0;

  priority_request_queue_with_tags uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .in_release_tag  (in_release_tag),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_payload_out (out_payload_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_req_t mk_req(prqt_pkg::opcode_t op,
                                        logic [prqt_pkg::CLS_W-1:0] prio,
                                        logic [prqt_pkg::PL_W-1:0] pl,
                                        logic [prqt_pkg::TAG_W-1:0] rt);
    queue_req_t r;
    r.op      = op;
    r.prio    = prio;
    r.payload = pl;
    r.rtag    = rt;
    return r;
  endfunction

  function automatic queue_reply_t predict_queue_op(queue_req_t r);
    queue_reply_t rep;
    int           cls;
    int           free_idx;
    int unsigned  slot;
    int           i;
    int           c;
    rep.status  = prqt_pkg::STS_OK;
    rep.tag     = '0;
    rep.payload = '0;
    if (r.prio == prqt_pkg::CLS_NORMAL) cls = int'(prqt_pkg::CLS_NORMAL);
    else if (r.prio == prqt_pkg::CLS_HIGH) cls = int'(prqt_pkg::CLS_HIGH);
    else cls = int'(prqt_pkg::CLS_MAX);
    case (r.op)
      prqt_pkg::OP_ENQ: begin
        free_idx = -1;
        for (i = prqt_pkg::NUM_IDS - 1; i >= 0; i--) if (!tag_live[i]) free_idx = i;
        if (free_idx < 0 || class_fill[cls] >= prqt_pkg::NUM_IDS) begin
          rep.status = prqt_pkg::STS_NO_TAG;
          n_refused++;
        end else begin
          slot = class_tail[cls];
          tag_live[free_idx] = 1'b1;
          class_slots[cls][slot].tag  = prqt_pkg::TAG_W'(free_idx + prqt_pkg::ID_BASE);
          class_slots[cls][slot].data = r.payload;
          class_tail[cls] = (slot + 1) % prqt_pkg::NUM_IDS;
          class_fill[cls]++;
          rep.tag = prqt_pkg::TAG_W'(free_idx + prqt_pkg::ID_BASE);
          n_alloc++;
        end
      end
      prqt_pkg::OP_DEQ: begin
        rep.status = prqt_pkg::STS_EMPTY;
        for (c = int'(prqt_pkg::CLS_MAX); c >= int'(prqt_pkg::CLS_NORMAL); c--) begin
          if (rep.status == prqt_pkg::STS_EMPTY && class_fill[c] != 0) begin
            slot = class_head[c];
            rep.status  = prqt_pkg::STS_OK;
            rep.tag     = class_slots[c][slot].tag;
            rep.payload = class_slots[c][slot].data;
            class_head[c] = (slot + 1) % prqt_pkg::NUM_IDS;
            class_fill[c]--;
          end
        end
        if (rep.status == prqt_pkg::STS_EMPTY) n_empty++;
        else n_served++;
      end
      prqt_pkg::OP_REL: begin
        if (r.rtag >= prqt_pkg::ID_BASE &&
            r.rtag < prqt_pkg::ID_BASE + prqt_pkg::NUM_IDS)
          tag_live[r.rtag - prqt_pkg::ID_BASE] = 1'b0;
        n_release++;
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic logic [prqt_pkg::TAG_W-1:0] pick_live_tag();
    int unsigned base;
    int unsigned k;
    int unsigned idx;
    base = $urandom_range(0, prqt_pkg::NUM_IDS - 1);
    for (k = 0; k < prqt_pkg::NUM_IDS; k++) begin
      idx = (base + k) % prqt_pkg::NUM_IDS;
      if (tag_live[idx]) return prqt_pkg::TAG_W'(idx + prqt_pkg::ID_BASE);
    end
    return prqt_pkg::TAG_W'($urandom_range(0, 127));
  endfunction

  task automatic add_row(prqt_pkg::opcode_t op, logic [prqt_pkg::CLS_W-1:0] prio,
                         logic [prqt_pkg::PL_W-1:0] pl, logic [prqt_pkg::TAG_W-1:0] rt,
                         bit fixed, prqt_pkg::status_t st,
                         logic [prqt_pkg::TAG_W-1:0] tg, logic [prqt_pkg::PL_W-1:0] po);
    script_row_t row;
    row.req          = mk_req(op, prio, pl, rt);
    row.fixed        = fixed;
    row.want.status  = st;
    row.want.tag     = tg;
    row.want.payload = po;
    script = {script, row};
  endtask

  // one command transfer; the model is stepped at the accepting edge
  task automatic issue(queue_req_t r, bit fixed = 1'b0,
                       queue_reply_t want = '{status: prqt_pkg::STS_OK,
                                              tag: '0, payload: '0});
    queue_reply_t got;
    queue_reply_t exp_rep;
    @(negedge clk);
    start           <= 1'b1;
    in_opcode       <= r.op;
    in_priority_req <= r.prio;
    in_payload      <= r.payload;
    in_release_tag  <= r.rtag;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    got = predict_queue_op(r);
    exp_rep = fixed ? want : got;
    pending_replies = {pending_replies, exp_rep};
    n_items++;
  endtask

  task automatic rest(int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        log_mismatch($sformatf("t=%0t unexpected reply: status %0d tag %0d payload %h",
                               $time, out_status, out_tag, out_payload_out));
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status || out_tag !== want.tag ||
            out_payload_out !== want.payload)
          log_mismatch($sformatf(
            "t=%0t reply: expected status %0d tag %0d payload %h, got %0d %0d %h",
            $time, want.status, want.tag, want.payload, out_status, out_tag,
            out_payload_out));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for replies");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    queue_req_t  r;
    int unsigned pick;
    int unsigned mode;
    int unsigned burst_left;
    int unsigned k;
    logic [prqt_pkg::TAG_W-1:0] victim;
    logic [prqt_pkg::PL_W-1:0]  pl;

    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_EMPTY, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_ENQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_OK, 7'd1, 32'h0);
    add_row(prqt_pkg::OP_ENQ, prqt_pkg::CLS_HIGH, 32'hFFFF_FFFF, 7'd0,
            1, prqt_pkg::STS_OK, 7'd2, 32'h0);
    add_row(prqt_pkg::OP_ENQ, 2'd3, 32'h8000_0001, 7'd127,
            1, prqt_pkg::STS_OK, 7'd3, 32'h0);
    add_row(prqt_pkg::OP_ENQ, prqt_pkg::CLS_MAX, 32'h7FFF_FFFE, 7'd0,
            1, prqt_pkg::STS_OK, 7'd4, 32'h0);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_OK, 7'd3, 32'h8000_0001);
    add_row(prqt_pkg::OP_DEQ, 2'd3, 32'hFFFF_FFFF, 7'd127,
            1, prqt_pkg::STS_OK, 7'd4, 32'h7FFF_FFFE);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_OK, 7'd2, 32'hFFFF_FFFF);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_OK, 7'd1, 32'h0);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_EMPTY, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, 2'd3, 32'hFFFF_FFFF, 7'd127,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd65,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd64,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd2,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_ENQ, prqt_pkg::CLS_NORMAL, 32'h1234_5678, 7'd0,
            1, prqt_pkg::STS_OK, 7'd2, 32'h0);
    // tag freed while still queued, then handed out again
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd2,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_ENQ, prqt_pkg::CLS_NORMAL, 32'hCAFE_F00D, 7'd0,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_NOP, 2'd3, 32'hFFFF_FFFF, 7'd127,
            1, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, 32'h0, 7'd0,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd1,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd3,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd4,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);
    add_row(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, 32'h0, 7'd2,
            0, prqt_pkg::STS_OK, 7'd0, 32'h0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      issue(script[i].req, script[i].fixed, script[i].want);
      rest($urandom_range(0, 2));
    end

    // exhaust the pool, overfill the normal class, then drain everything
    for (k = 0; k < prqt_pkg::NUM_IDS + 1; k++)
      issue(mk_req(prqt_pkg::OP_ENQ, prqt_pkg::CLS_NORMAL, $urandom,
                   prqt_pkg::TAG_W'($urandom)));
    victim = prqt_pkg::TAG_W'($urandom_range(prqt_pkg::ID_BASE,
                                              prqt_pkg::ID_BASE + prqt_pkg::NUM_IDS - 1));
    issue(mk_req(prqt_pkg::OP_REL, prqt_pkg::CLS_HIGH, $urandom, victim));
    issue(mk_req(prqt_pkg::OP_ENQ, prqt_pkg::CLS_NORMAL, $urandom, 7'd0));
    issue(mk_req(prqt_pkg::OP_ENQ, prqt_pkg::CLS_MAX, $urandom, 7'd0));
    for (k = 0; k < prqt_pkg::NUM_IDS + 2; k++) begin
      issue(mk_req(prqt_pkg::OP_DEQ, prqt_pkg::CLS_NORMAL, $urandom, 7'd0));
      if ($urandom_range(0, 9) == 0) rest($urandom_range(1, 5));
    end
    for (k = prqt_pkg::ID_BASE; k < prqt_pkg::ID_BASE + prqt_pkg::NUM_IDS; k++)
      issue(mk_req(prqt_pkg::OP_REL, prqt_pkg::CLS_NORMAL, $urandom, prqt_pkg::TAG_W'(k)));

    wait_drained();

    mode = 0;
    burst_left = $urandom_range(1, 24);
    while (n_items < 1600) begin
      if (n_items % 50 == 0) mode = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) pl = $urandom_range(0, 1) ? '1 : '0;
      else pl = $urandom;
      r = mk_req(prqt_pkg::OP_NOP, prqt_pkg::CLS_W'($urandom_range(0, 3)), pl,
                 prqt_pkg::TAG_W'($urandom_range(0, 127)));
      case (mode)
        0: r.op = pick < 40 ? prqt_pkg::OP_ENQ : pick < 70 ? prqt_pkg::OP_DEQ :
                  pick < 96 ? prqt_pkg::OP_REL : prqt_pkg::OP_NOP;
        1: r.op = pick < 75 ? prqt_pkg::OP_ENQ : pick < 86 ? prqt_pkg::OP_DEQ :
                  pick < 97 ? prqt_pkg::OP_REL : prqt_pkg::OP_NOP;
        default: r.op = pick < 15 ? prqt_pkg::OP_ENQ : pick < 60 ? prqt_pkg::OP_DEQ :
                        pick < 97 ? prqt_pkg::OP_REL : prqt_pkg::OP_NOP;
      endcase
      if (r.op == prqt_pkg::OP_REL && $urandom_range(0, 99) < 85) r.rtag = pick_live_tag();
      issue(r);
      if (--burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 9) < 7) rest($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Covered %0d transfers: %0d tags allocated, %0d enqueues refused,",
             n_items, n_alloc, n_refused);
    $display("%0d requests served, %0d dequeues on empty queues, %0d releases",
             n_served, n_empty, n_release);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- priority_request_queue_with_tags.f -----
hdl/prqt_pkg.sv
hdl/priority_request_queue_with_tags.sv
hdl/prqt_checker.sv
verif/priority_request_queue_with_tags_tb.sv
